FILE: rtl/lnps_pkg.sv
// lnps_pkg: shared types and constants of the last-note priority stack
// used by lnps_cell and last_note_priority_stack, depends on nothing
package lnps_pkg;

  localparam int unsigned StackDepthDef = 16;
  localparam int unsigned NoteW         = 7;
  localparam int unsigned BendW         = 14;
  localparam int unsigned ShiftW        = 4;
  localparam int unsigned SoundW        = 9;

  localparam logic [BendW-1:0] BendCenter = BendW'(8192);

  typedef enum logic [1:0] {
    OP_NOTE_ON  = 2'd0,
    OP_NOTE_OFF = 2'd1,
    OP_BEND     = 2'd2,
    OP_NONE     = 2'd3
  } lnps_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_UPDATE,
    ST_RESULT
  } lnps_state_e;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic compare;
    logic push;
    logic pull;
  } lnps_cell_ctrl_t;

endpackage

FILE: rtl/lnps_cell.sv
// lnps_cell: one entry of the note stack, holds a note and its match flag
// depends on lnps_pkg
module lnps_cell (
  input  logic                          clk_i,
  input  lnps_pkg::lnps_cell_ctrl_t     ctrl_i,
  input  logic [lnps_pkg::NoteW-1:0]    req_note_i,
  input  logic [lnps_pkg::NoteW-1:0]    prev_note_i,
  input  logic [lnps_pkg::NoteW-1:0]    next_note_i,
  input  logic                          valid_i,
  input  logic                          hit_before_i,
  output logic                          hit_after_o,
  output logic                          match_o,
  output logic [lnps_pkg::NoteW-1:0]    note_o
);
  import lnps_pkg::*;

  logic [NoteW-1:0] note_q, note_d;
  logic             match_q, match_d;

  always_comb begin
    note_d  = note_q;
    match_d = match_q;
    if (ctrl_i.compare) begin
      match_d = valid_i && (note_q == req_note_i);
    end
    // push: every cell up to and including the held copy moves back by one
    if (ctrl_i.push && !hit_before_i) begin
      note_d = prev_note_i;
    end
    // pull: the matching cell and all behind it close the gap
    if (ctrl_i.pull && (hit_before_i || match_q)) begin
      note_d = next_note_i;
    end
  end

  always_ff @(posedge clk_i) begin
    note_q  <= note_d;
    match_q <= match_d;
  end

  assign hit_after_o = hit_before_i | match_q;
  assign match_o     = match_q;
  assign note_o      = note_q;

endmodule

FILE: rtl/last_note_priority_stack.sv
// last_note_priority_stack: top level, sequencer, count, bend and output register
// depends on lnps_pkg and lnps_cell
//
// Monophonic last-note priority stack. Each request (note on, note off, pitch
// bend) produces one result: the front note plus twelve times octave_shift
// (0 when no note is held), a playing flag and the bend state. The notes live
// in a row of STACK_DEPTH cells. A request passes through the idle state that
// ends with its acceptance, a compare step in which every cell compares its
// note, an update step in which the cells shift towards or away from the
// front, and a result step that loads the output register.
// The sequencer takes a new request only once the previous one has reached
// the output register, so it is never through with two requests at once;
// a result that is not taken holds the sequencer in its last step until the
// output register frees up. octave_shift may be written whenever the block is
// idle and applies to the next result.
module last_note_priority_stack #(
  parameter int unsigned STACK_DEPTH = lnps_pkg::StackDepthDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [lnps_pkg::ShiftW-1:0]       cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        opcode_i,
  input  logic [lnps_pkg::NoteW-1:0]        note_number_i,
  input  logic [lnps_pkg::BendW-1:0]        bend_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [lnps_pkg::SoundW-1:0] sounding_note_o,
  output logic                              playing_o,
  output logic [lnps_pkg::BendW-1:0]        bend_now_o,
  output logic                              bend_changed_o
);
  import lnps_pkg::*;

  localparam int unsigned CntW = $clog2(STACK_DEPTH + 1);

  lnps_state_e     state_q, state_d;
  lnps_cell_ctrl_t ctrl;

  lnps_op_e         op_q;
  logic [NoteW-1:0] req_note_q;
  logic [BendW-1:0] req_bend_q;

  logic [CntW-1:0]        count_q, count_d;
  logic [BendW-1:0]       bend_q, bend_d;
  logic                   bend_flag_q, bend_flag_d;
  logic signed [ShiftW-1:0] shift_q;

  logic                     out_valid_q;
  logic signed [SoundW-1:0] sound_q;
  logic                     playing_q;
  logic [BendW-1:0]         bend_out_q;
  logic                     bend_chg_q;

  logic [NoteW-1:0]     note_arr  [STACK_DEPTH];
  logic [STACK_DEPTH:0] hit_chain;
  logic [STACK_DEPTH-1:0] match_vec;
  logic                 hit;
  logic                 out_load;

  // row of cells
  assign hit_chain[0] = 1'b0;
  for (genvar gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
    logic [NoteW-1:0] prev_note, next_note;
    if (gi == 0) begin : g_first
      assign prev_note = req_note_q;
    end else begin : g_mid
      assign prev_note = note_arr[gi-1];
    end
    if (gi == STACK_DEPTH - 1) begin : g_last
      assign next_note = '0;
    end else begin : g_inner
      assign next_note = note_arr[gi+1];
    end
    lnps_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .req_note_i   (req_note_q),
      .prev_note_i  (prev_note),
      .next_note_i  (next_note),
      .valid_i      (CntW'(gi) < count_q),
      .hit_before_i (hit_chain[gi]),
      .hit_after_o  (hit_chain[gi+1]),
      .match_o      (match_vec[gi]),
      .note_o       (note_arr[gi])
    );
  end
  assign hit = hit_chain[STACK_DEPTH];

  // sequencer: next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) begin
        state_d = ST_MATCH;
      end
      ST_MATCH:  state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_RESULT;
      ST_RESULT: if (!out_valid_q || out_ready_i) begin
        state_d = ST_IDLE;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    ctrl       = '0;
    in_ready_o = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      ST_IDLE:   in_ready_o = 1'b1;
      ST_MATCH:  ctrl.compare = 1'b1;
      ST_UPDATE: begin
        ctrl.push = (op_q == OP_NOTE_ON);
        ctrl.pull = (op_q == OP_NOTE_OFF);
      end
      ST_RESULT: out_load = !out_valid_q || out_ready_i;
      default:   ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q       <= lnps_op_e'(opcode_i);
      req_note_q <= note_number_i;
      req_bend_q <= bend_value_i;
    end
  end

  // held count and bend state
  always_comb begin
    count_d     = count_q;
    bend_d      = bend_q;
    bend_flag_d = bend_flag_q;
    if (state_q == ST_UPDATE) begin
      unique case (op_q)
        OP_NOTE_ON:  if (!hit && (count_q != CntW'(STACK_DEPTH))) begin
          count_d = count_q + CntW'(1);
        end
        OP_NOTE_OFF: if (hit) begin
          count_d = count_q - CntW'(1);
        end
        OP_BEND: begin
          bend_flag_d = (req_bend_q != bend_q);
          bend_d      = req_bend_q;
        end
        OP_NONE: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      bend_q      <= BendCenter;
      bend_flag_q <= 1'b0;
      shift_q     <= '0;
    end else begin
      count_q     <= count_d;
      bend_q      <= bend_d;
      bend_flag_q <= bend_flag_d;
      if (cfg_we_i) begin
        shift_q <= cfg_wdata_i;
      end
    end
  end

  // result: front note plus 12 * shift, as 8 * shift + 4 * shift
  logic signed [SoundW-1:0] shift_ext, offset, front_sum;
  assign shift_ext = SoundW'(shift_q);
  assign offset    = (shift_ext <<< 3) + (shift_ext <<< 2);
  assign front_sum = $signed({{(SoundW-NoteW){1'b0}}, note_arr[0]}) + offset;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      sound_q    <= (count_q != '0) ? front_sum : '0;
      playing_q  <= (count_q != '0);
      bend_out_q <= bend_q;
      bend_chg_q <= bend_flag_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sounding_note_o = sound_q;
  assign playing_o       = playing_q;
  assign bend_now_o      = bend_out_q;
  assign bend_changed_o  = bend_chg_q;

  // a held note sits in one cell only
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPDATE) |-> $onehot0(match_vec))
    else $error("more than one cell matched the request note");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(STACK_DEPTH))
    else $error("held count beyond stack depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPDATE && op_q == OP_NOTE_ON) |=> (count_q != '0))
    else $error("note on left the stack empty");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPDATE && op_q == OP_NOTE_OFF && hit) |=>
      (count_q == $past(count_q) - CntW'(1)))
    else $error("note off of a held note did not shrink the stack");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_MATCH))
    else $error("accepted request did not start a compare");

endmodule

FILE: tb/tb_last_note_priority_stack.sv
// tb_last_note_priority_stack: self-checking bench for the last-note priority stack,
// a directed request table then random phases at several octave shifts, scored by a predictor
// depends on lnps_pkg and last_note_priority_stack
module tb_last_note_priority_stack;
  timeunit 1ns;
  timeprecision 1ps;

  import lnps_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned LongHoldCycles = 60;
  localparam int unsigned NumPhases = 8;
  localparam int unsigned PhaseRequests = 165;

  typedef struct packed {
    logic [SoundW-1:0] sound;
    logic              play;
    logic [BendW-1:0]  bend;
    logic              chg;
  } note_result_t;

  typedef struct packed {
    lnps_op_e         op;
    logic [NoteW-1:0] note;
    logic [BendW-1:0] bend;
    logic             typed;
    note_result_t     res;
  } request_row_t;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [ShiftW-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready_o;
  logic [1:0] in_op = '0;
  logic [NoteW-1:0] in_note = '0;
  logic [BendW-1:0] in_bend = '0;
  logic out_valid_o;
  logic out_ready = 1'b0;
  logic signed [SoundW-1:0] sounding_note_o;
  logic playing_o;
  logic [BendW-1:0] bend_now_o;
  logic bend_changed_o;

  // predictor state
  logic [NoteW-1:0] held_stack[$];
  logic [BendW-1:0] bend_level = BendCenter;
  logic bend_moved = 1'b0;
  logic signed [ShiftW-1:0] shift_setting = '0;

  note_result_t expected_notes[$];
  int unsigned mismatch_count = 0;
  int unsigned next_gap = 1;
  bit burst = 1'b0;
  bit hold_off_req = 1'b0;

  // typed results assume octave shift 0 straight after reset
  request_row_t directed_rows[25] = '{
    '{OP_NONE,     7'd0,   14'd0,     1'b1, '{9'd0,   1'b0, 14'd8192,  1'b0}},
    '{OP_NOTE_OFF, 7'd127, 14'd0,     1'b1, '{9'd0,   1'b0, 14'd8192,  1'b0}},
    '{OP_BEND,     7'd0,   14'd8192,  1'b1, '{9'd0,   1'b0, 14'd8192,  1'b0}},
    '{OP_BEND,     7'd127, 14'd0,     1'b1, '{9'd0,   1'b0, 14'd0,     1'b1}},
    '{OP_BEND,     7'd0,   14'd16383, 1'b1, '{9'd0,   1'b0, 14'd16383, 1'b1}},
    '{OP_NOTE_ON,  7'd0,   14'd0,     1'b1, '{9'd0,   1'b1, 14'd16383, 1'b1}},
    '{OP_NOTE_ON,  7'd127, 14'd16383, 1'b1, '{9'd127, 1'b1, 14'd16383, 1'b1}},
    '{OP_NOTE_ON,  7'd0,   14'd0,     1'b1, '{9'd0,   1'b1, 14'd16383, 1'b1}},
    '{OP_NOTE_ON,  7'd1,   14'd0,     1'b0, '0},
    '{OP_NOTE_ON,  7'd2,   14'd0,     1'b0, '0},
    '{OP_NOTE_ON,  7'd3,   14'd0,     1'b0, '0},
    '{OP_NOTE_ON,  7'd4,   14'd0,     1'b0, '0},
    '{OP_NOTE_ON,  7'd5,   14'd0,     1'b0, '0},
    '{OP_NOTE_ON,  7'd6,   14'd0,     1'b0, '0},
    '{OP_NOTE_ON,  7'd7,   14'd0,     1'b0, '0},
    '{OP_NOTE_ON,  7'd8,   14'd0,     1'b0, '0},
    '{OP_NOTE_ON,  7'd9,   14'd0,     1'b0, '0},
    '{OP_NOTE_ON,  7'd10,  14'd0,     1'b0, '0},
    '{OP_NOTE_ON,  7'd11,  14'd0,     1'b0, '0},
    '{OP_NOTE_ON,  7'd12,  14'd0,     1'b0, '0},
    '{OP_NOTE_ON,  7'd13,  14'd0,     1'b0, '0},
    '{OP_NOTE_ON,  7'd14,  14'd0,     1'b0, '0},
    '{OP_NOTE_ON,  7'd15,  14'd0,     1'b0, '0},
    '{OP_NOTE_OFF, 7'd127, 14'd0,     1'b0, '0},
    '{OP_BEND,     7'd64,  14'd16383, 1'b0, '0}
  };

  last_note_priority_stack dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready_o),
    .opcode_i        (in_op),
    .note_number_i   (in_note),
    .bend_value_i    (in_bend),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready),
    .sounding_note_o (sounding_note_o),
    .playing_o       (playing_o),
    .bend_now_o      (bend_now_o),
    .bend_changed_o  (bend_changed_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic note_result_t advance_note_stack(input lnps_op_e op,
                                                     input logic [NoteW-1:0] note,
                                                     input logic [BendW-1:0] bend);
    note_result_t res;
    int sound;
    int idx[$];
    if (op == OP_NOTE_ON || op == OP_NOTE_OFF) begin
      idx = held_stack.find_first_index(n) with (n == note);
      if (idx.size() != 0) held_stack.delete(idx[0]);
      if (op == OP_NOTE_ON) begin
        // full stack loses its oldest note
        if (held_stack.size() >= StackDepthDef) void'(held_stack.pop_back());
        held_stack.push_front(note);
      end
    end else if (op == OP_BEND) begin
      bend_moved = (bend != bend_level);
      bend_level = bend;
    end
    sound = 0;
    if (held_stack.size() != 0) sound = int'(held_stack[0]) + 12 * int'(shift_setting);
    res.sound = sound[SoundW-1:0];
    res.play = (held_stack.size() != 0);
    res.bend = bend_level;
    res.chg = bend_moved;
    return res;
  endfunction

  task automatic drive_request(input lnps_op_e op, input logic [NoteW-1:0] note,
                               input logic [BendW-1:0] bend, input logic typed,
                               input note_result_t typed_res);
    note_result_t predicted;
    repeat (next_gap) @(posedge clk_i);
    in_valid <= 1'b1;
    in_op <= op;
    in_note <= note;
    in_bend <= bend;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    predicted = advance_note_stack(op, note, bend);
    expected_notes.push_back(typed ? typed_res : predicted);
    next_gap = burst ? 0 : $urandom_range(0, 6);
    // valid stays up when the next request follows straight on
    if (next_gap != 0) in_valid <= 1'b0;
  endtask

  task automatic set_octave_shift(input int shift);
    if (next_gap == 0) begin
      in_valid <= 1'b0;
      next_gap = 1;
    end
    while (expected_notes.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= ShiftW'(shift);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    shift_setting = ShiftW'(shift);
  endtask

  task automatic run_random_phase(input int unsigned count, input int unsigned on_pct);
    lnps_op_e op;
    logic [NoteW-1:0] note;
    logic [BendW-1:0] bend;
    int unsigned pick;
    int unsigned base;
    base = $urandom_range(0, 108);
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < on_pct) op = OP_NOTE_ON;
      else if (pick < on_pct + 30) op = OP_NOTE_OFF;
      else if (pick < 96) op = OP_BEND;
      else op = OP_NONE;
      note = NoteW'($urandom_range(0, 127));
      // mostly release held notes and replay a narrow range so the stack gets hits
      if (op == OP_NOTE_OFF && held_stack.size() != 0 && $urandom_range(0, 9) < 7)
        note = held_stack[$urandom_range(0, held_stack.size() - 1)];
      else if ($urandom_range(0, 9) < 6)
        note = NoteW'(base + $urandom_range(0, 19));
      pick = $urandom_range(0, 9);
      if (pick < 4) bend = bend_level;
      else if (pick == 4) bend = '0;
      else if (pick == 5) bend = '1;
      else bend = BendW'($urandom_range(0, 16383));
      drive_request(op, note, bend, 1'b0, '0);
    end
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin : result_sink
    int unsigned stall;
    wait (rst_n === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (LongHoldCycles) @(posedge clk_i);
        hold_off_req = 1'b0;
      end
      stall = burst ? 0 : $urandom_range(0, 6);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
    end
  end

  always @(posedge clk_i) begin : check_results
    note_result_t want;
    if (rst_n && out_valid_o && out_ready) begin
      if (expected_notes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: note %0d playing %0b bend %0d changed %0b",
                   sounding_note_o, playing_o, bend_now_o, bend_changed_o);
      end else begin
        want = expected_notes.pop_front();
        if (sounding_note_o !== want.sound || playing_o !== want.play ||
            bend_now_o !== want.bend || bend_changed_o !== want.chg) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: exp note %0d play %0b bend %0d chg %0b, got %0d %0b %0d %0b",
                     $signed(want.sound), want.play, want.bend, want.chg,
                     sounding_note_o, playing_o, bend_now_o, bend_changed_o);
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no handshake for %0d cycles", WatchdogLimit);
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    int plan[5] = '{4, -4, 7, -8, 0};
    int unsigned ph;
    repeat (7) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);
    set_octave_shift(0);
    foreach (directed_rows[i])
      drive_request(directed_rows[i].op, directed_rows[i].note, directed_rows[i].bend,
                    directed_rows[i].typed, directed_rows[i].res);
    for (ph = 0; ph < NumPhases; ph++) begin
      set_octave_shift(ph < 5 ? plan[ph] : int'($urandom_range(0, 15)) - 8);
      burst = (ph == 2 || ph == 6);
      // receiver goes quiet while requests keep coming, so the block backs up
      if (ph == 1) hold_off_req = 1'b1;
      run_random_phase(PhaseRequests, ph == 1 ? 65 : 40 + (ph % 4) * 8);
    end
    burst = 1'b0;
    if (next_gap == 0) in_valid <= 1'b0;
    while (expected_notes.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
    if (expected_notes.size() != 0) begin
      $display("%0d results never arrived", expected_notes.size());
      mismatch_count += expected_notes.size();
    end
    if (mismatch_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: last_note_priority_stack.f
rtl/lnps_pkg.sv
rtl/lnps_cell.sv
rtl/last_note_priority_stack.sv
tb/tb_last_note_priority_stack.sv
